[rtl/jsu_pkg.sv]
// Shared types, constants and the helper function of the JSON string unescaper.
package jsu_pkg;

    localparam int BYTE_W     = 8;
    localparam int CAP_W      = 12;
    localparam int HEX_DIGITS = 4;
    localparam int HCNT_W     = 3;
    localparam int UTF_CNT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 12'd64;

    // Characters that steer the escape decoder.
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;

    localparam logic [BYTE_W-1:0] CTL_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CTL_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CTL_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CTL_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CTL_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

    // UTF-8 encoding limits and marker bits.
    localparam logic [15:0]       CP_LIMIT_1B = 16'h0080;
    localparam logic [15:0]       CP_LIMIT_2B = 16'h0800;
    localparam logic [BYTE_W-1:0] UTF_LEAD2   = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF_LEAD3   = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF_CONT    = 8'h80;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_ESC,
        PH_HEX
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_HEX,
        S_UTF,
        S_REPLAY,
        S_FIN
    } t_state;

    typedef enum logic [0:0] {
        SRC_INPUT,
        SRC_REPLAY
    } t_src;

    typedef struct packed {
        logic load;
        logic feed;
        t_src src;
        logic hex;
        logic utf;
        logic fin_u;
        logic fin_esc;
        logic fin_term;
    } t_cmd;

    typedef struct packed {
        logic   out_free;
        logic   in_valid;
        logic   in_eos;
        t_phase phase;
        logic   hex_arm;
        logic   hex_good;
        logic   utf_multi;
        logic   utf_last;
        logic   rep_last;
        logic   held_zero;
    } t_status;

    // Returns {is_hex, value} for one ASCII character.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

[rtl/jsu_ctrl.sv]
// Sequencer of the JSON string unescaper: walks each item through load, feed, hex, UTF-8, replay and end steps.
module jsu_ctrl import jsu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state after_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.src       = SRC_INPUT;
        o_s_axis_tready = (r_state == S_IDLE);
        after_item      = i_status.in_eos ? S_FIN : S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FEED;
                end
            end
            S_FEED: begin
                if (i_status.out_free) begin
                    o_cmd.feed = i_status.in_valid;
                    if (i_status.in_valid && i_status.hex_arm) begin
                        n_state = S_HEX;
                    end else begin
                        n_state = after_item;
                    end
                end
            end
            S_HEX: begin
                if (i_status.out_free) begin
                    o_cmd.hex = 1'b1;
                    if (i_status.hex_good && i_status.utf_multi) begin
                        n_state = S_UTF;
                    end else if (i_status.hex_good) begin
                        n_state = after_item;
                    end else begin
                        n_state = S_REPLAY;
                    end
                end
            end
            S_UTF: begin
                if (i_status.out_free) begin
                    o_cmd.utf = 1'b1;
                    if (i_status.utf_last) begin
                        n_state = after_item;
                    end
                end
            end
            S_REPLAY: begin
                if (i_status.out_free) begin
                    o_cmd.feed = 1'b1;
                    o_cmd.src  = SRC_REPLAY;
                    if (i_status.rep_last) begin
                        n_state = after_item;
                    end
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    case (i_status.phase)
                        PH_HEX: begin
                            o_cmd.fin_u = 1'b1;
                            n_state     = i_status.held_zero ? S_FIN : S_REPLAY;
                        end
                        PH_ESC: begin
                            o_cmd.fin_esc = 1'b1;
                        end
                        default: begin
                            o_cmd.fin_term = 1'b1;
                            n_state        = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.feed, o_cmd.hex, o_cmd.utf,
                  o_cmd.fin_u, o_cmd.fin_esc, o_cmd.fin_term}))
        else $error("jsu_ctrl: more than one datapath command at once");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEX) |-> ($past(r_state) == S_FEED || $past(r_state) == S_HEX))
        else $error("jsu_ctrl: hex completion not reached from an input feed");
`endif

endmodule

[rtl/jsu_dp.sv]
// Datapath of the JSON string unescaper: escape decoder, held digits, UTF-8 encoder, replay buffer, output register.
module jsu_dp import jsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_in_valid,
    input  logic              i_in_eos,
    input  logic              i_m_axis_tready,
    output logic              o_m_axis_tvalid,
    output logic [BYTE_W-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    input  t_cmd              i_cmd,
    output t_status           o_status
);

    logic [CAP_W-1:0]     r_cap;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_valid;
    logic                 r_in_eos;
    t_phase               r_phase;
    t_phase               n_phase;
    logic [HCNT_W-1:0]    r_held_cnt;
    logic [HCNT_W-1:0]    n_held_cnt;
    logic [CAP_W-1:0]     r_written;
    logic [CAP_W-1:0]     n_written;
    logic [BYTE_W-1:0]    r_held [HEX_DIGITS];
    logic [BYTE_W-1:0]    r_rep  [HEX_DIGITS];
    logic [HCNT_W-1:0]    r_rep_cnt;
    logic [1:0]           r_rep_idx;
    logic [UTF_CNT_W-1:0] r_utf_idx;
    logic [UTF_CNT_W-1:0] n_utf_idx;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;

    logic [CAP_W-1:0]     cap_eff;
    logic                 room1;
    logic                 fits;
    logic [BYTE_W-1:0]    feed_byte;
    logic [4:0]           dig [HEX_DIGITS];
    logic                 all_hex;
    logic [15:0]          cp;
    logic [UTF_CNT_W-1:0] utf_cnt;
    logic [BYTE_W-1:0]    utf_b0;
    logic [BYTE_W-1:0]    utf_b1;
    logic [BYTE_W-1:0]    utf_b2;
    logic [BYTE_W-1:0]    utf_sel;
    logic                 held_wr;
    logic                 rep_load;
    logic                 put_req;
    logic [BYTE_W-1:0]    put_byte;
    logic                 emit;
    logic [BYTE_W-1:0]    emit_byte;
    logic                 emit_last;
    logic                 out_free;

    // A capacity of zero behaves as a capacity of one.
    assign cap_eff   = (r_cap == '0) ? CAP_W'(1) : r_cap;
    assign room1     = ({1'b0, r_written} + 13'd1) < {1'b0, cap_eff};
    assign fits      = ({1'b0, r_written} + {11'd0, utf_cnt}) < {1'b0, cap_eff};
    assign feed_byte = (i_cmd.src == SRC_REPLAY) ? r_rep[r_rep_idx] : r_in_byte;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    // Decode of the four held digits; the first held digit is the most significant.
    always_comb begin
        for (int i = 0; i < HEX_DIGITS; i++) begin
            dig[i] = hex_digit(r_held[i]);
        end
        all_hex = dig[0][4] & dig[1][4] & dig[2][4] & dig[3][4];
        cp      = {dig[0][3:0], dig[1][3:0], dig[2][3:0], dig[3][3:0]};
        if (cp < CP_LIMIT_1B) begin
            utf_cnt = 2'd1;
            utf_b0  = cp[7:0];
            utf_b1  = UTF_CONT;
            utf_b2  = UTF_CONT;
        end else if (cp < CP_LIMIT_2B) begin
            utf_cnt = 2'd2;
            utf_b0  = UTF_LEAD2 | {3'd0, cp[10:6]};
            utf_b1  = UTF_CONT | {2'd0, cp[5:0]};
            utf_b2  = UTF_CONT;
        end else begin
            utf_cnt = 2'd3;
            utf_b0  = UTF_LEAD3 | {4'd0, cp[15:12]};
            utf_b1  = UTF_CONT | {2'd0, cp[11:6]};
            utf_b2  = UTF_CONT | {2'd0, cp[5:0]};
        end
        case (r_utf_idx)
            2'd1:    utf_sel = utf_b1;
            2'd2:    utf_sel = utf_b2;
            default: utf_sel = utf_b0;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_held_cnt = r_held_cnt;
        n_written  = r_written;
        n_utf_idx  = r_utf_idx;
        held_wr    = 1'b0;
        rep_load   = 1'b0;
        put_req    = 1'b0;
        put_byte   = feed_byte;
        emit       = 1'b0;
        emit_byte  = TERM_BYTE;
        emit_last  = 1'b0;

        if (i_cmd.feed) begin
            case (r_phase)
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    put_req = 1'b1;
                    case (feed_byte)
                        CH_N: put_byte = CTL_LF;
                        CH_R: put_byte = CTL_CR;
                        CH_T: put_byte = CTL_TAB;
                        CH_B: put_byte = CTL_BS;
                        CH_F: put_byte = CTL_FF;
                        CH_U: begin
                            put_req    = 1'b0;
                            n_phase    = PH_HEX;
                            n_held_cnt = '0;
                        end
                        default: put_byte = feed_byte;
                    endcase
                end
                PH_HEX: begin
                    held_wr    = (r_held_cnt < HCNT_W'(HEX_DIGITS));
                    n_held_cnt = r_held_cnt + 3'd1;
                end
                default: begin
                    n_phase = PH_PLAIN;
                    // A full buffer swallows even a backslash.
                    if (room1) begin
                        if (feed_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            put_req = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (i_cmd.hex) begin
            n_phase    = PH_PLAIN;
            n_held_cnt = '0;
            put_req    = 1'b1;
            if (all_hex && fits) begin
                put_byte  = utf_b0;
                n_utf_idx = 2'd1;
            end else begin
                put_byte = CH_QMARK;
                rep_load = 1'b1;
            end
        end

        if (i_cmd.utf) begin
            put_req   = 1'b1;
            put_byte  = utf_sel;
            n_utf_idx = r_utf_idx + 2'd1;
        end

        if (i_cmd.fin_u) begin
            put_req    = 1'b1;
            put_byte   = CH_U;
            rep_load   = 1'b1;
            n_phase    = PH_PLAIN;
            n_held_cnt = '0;
        end

        if (i_cmd.fin_esc) begin
            n_phase = PH_PLAIN;
        end

        if (put_req && room1) begin
            emit      = 1'b1;
            emit_byte = put_byte;
            n_written = r_written + 12'd1;
        end

        if (i_cmd.fin_term) begin
            emit       = 1'b1;
            emit_byte  = TERM_BYTE;
            emit_last  = 1'b1;
            n_written  = '0;
            n_held_cnt = '0;
            n_phase    = PH_PLAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_phase     <= PH_PLAIN;
            r_held_cnt  <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cap <= i_cfg_data;
            end
            r_phase    <= n_phase;
            r_held_cnt <= n_held_cnt;
            r_written  <= n_written;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_byte  <= i_in_byte;
            r_in_valid <= i_in_valid;
            r_in_eos   <= i_in_eos;
        end
        if (held_wr) begin
            r_held[r_held_cnt[1:0]] <= feed_byte;
        end
        // The replay buffer is a snapshot, so replayed bytes may refill the held digits.
        if (rep_load) begin
            r_rep     <= r_held;
            r_rep_cnt <= r_held_cnt;
            r_rep_idx <= '0;
        end else if (i_cmd.feed && (i_cmd.src == SRC_REPLAY)) begin
            r_rep_idx <= r_rep_idx + 2'd1;
        end
        r_utf_idx <= n_utf_idx;
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        o_status           = '0;
        o_status.out_free  = out_free;
        o_status.in_valid  = r_in_valid;
        o_status.in_eos    = r_in_eos;
        o_status.phase     = r_phase;
        o_status.hex_arm   = (r_phase == PH_HEX) && (r_held_cnt == HCNT_W'(HEX_DIGITS - 1));
        o_status.hex_good  = all_hex && fits;
        o_status.utf_multi = (utf_cnt != 2'd1);
        o_status.utf_last  = (r_utf_idx == (utf_cnt - 2'd1));
        o_status.rep_last  = ({1'b0, r_rep_idx} == (r_rep_cnt - 3'd1));
        o_status.held_zero = (r_held_cnt == '0);
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= HCNT_W'(HEX_DIGITS))
        else $error("jsu_dp: held digit count beyond the escape length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hex |-> (r_held_cnt == HCNT_W'(HEX_DIGITS) && r_phase == PH_HEX))
        else $error("jsu_dp: hex completion without a full set of digits");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_byte == TERM_BYTE))
        else $error("jsu_dp: terminator transfer carries a nonzero byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("jsu_dp: output register overwritten while stalled");
`endif

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// Top level of the JSON string unescaper producing UTF-8 bytes.
// Each input transfer carries one raw string-body byte (tuser says whether the byte is real,
// tlast ends the string); the block emits the decoded bytes and then a zero terminator with
// tlast set. The block works on one item at a time through a single byte-wide decode step:
// a plain item is accepted and then decoded, a completed \u escape then emits its UTF-8 bytes
// one by one, a rejected \u emits a '?' and then replays its four held bytes, and an
// end-of-string item emits the terminator after any pending escape steps and replayed bytes.
// Any cycle in which the output register holds an untaken byte stalls the sequencer.
// Capacity writes are taken at any time but are meant for idle gaps.
module json_string_unescape_utf8_top import jsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,       // out_capacity
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic              i_s_axis_tuser,   // [0] byte_valid
    input  logic              i_s_axis_tlast,   // end_of_string
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic              o_m_axis_tlast    // out_last
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    jsu_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    jsu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_in_byte       (i_s_axis_tdata),
        .i_in_valid      (i_s_axis_tuser),
        .i_in_eos        (i_s_axis_tlast),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
